// ===== rtl/bpa_pkg.sv =====
// bpa_pkg: constants and shared types of the buddy page allocator
// no dependencies; imported by bpa_free_lists and buddy_page_allocator
`default_nettype none

package bpa_pkg;

  // geometry of the frame pool
  localparam int unsigned MaxOrder  = 10;
  localparam int unsigned PageShift = 12;
  localparam int unsigned NumLists  = MaxOrder + 1;
  localparam int unsigned FrameW    = 10;
  localparam int unsigned NumFrames = 1 << FrameW;
  localparam int unsigned OrdW      = 4;
  localparam int unsigned AddrW     = 33;
  localparam int unsigned DataW     = 32;
  localparam int unsigned PaddrW    = 2;

  // link entry in the frame memory: successor valid flag and successor frame
  localparam int unsigned LinkW = FrameW + 1;

  // register map
  localparam logic [PaddrW-1:0] RegMemoryBase = PaddrW'(0);

  typedef logic [FrameW-1:0] frame_t;
  typedef logic [OrdW-1:0]   ord_t;

  // update of the free list heads
  typedef struct packed {
    logic   pop;
    ord_t   pop_ord;
    logic   pop_more;
    frame_t pop_next;
    logic   push;
    ord_t   push_ord;
    frame_t push_frame;
  } list_cmd_t;

  // search result and head lookup from the free list heads
  typedef struct packed {
    logic   found;
    ord_t   found_ord;
    frame_t cur_head;
    logic   cur_nonempty;
  } list_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bpa_ram.sv =====
// bpa_ram: generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module bpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpa_free_lists.sv =====
// bpa_free_lists: head frame and non-empty flag of every free list,
// smallest-fit search; depends on bpa_pkg
`default_nettype none

module bpa_free_lists
  import bpa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ord_t       req_ord_i,
  input  wire ord_t       cur_ord_i,
  input  wire list_cmd_t  cmd_i,
  output      list_stat_t stat_o
);

  localparam logic [NumLists-1:0] TopOnly = NumLists'(1) << MaxOrder;

  frame_t              head_q [NumLists];
  frame_t              head_d [NumLists];
  logic [NumLists-1:0] nonempty_q, nonempty_d;

  // lowest non-empty list at or above the requested order
  always_comb begin
    stat_o.found     = 1'b0;
    stat_o.found_ord = '0;
    for (int i = NumLists - 1; i >= 0; i--) begin
      if (nonempty_q[i] && (OrdW'(i) >= req_ord_i)) begin
        stat_o.found     = 1'b1;
        stat_o.found_ord = OrdW'(i);
      end
    end
    stat_o.cur_head     = head_q[cur_ord_i];
    stat_o.cur_nonempty = nonempty_q[cur_ord_i];
  end

  // pop and push always touch different lists
  always_comb begin
    head_d     = head_q;
    nonempty_d = nonempty_q;
    if (cmd_i.pop) begin
      head_d[cmd_i.pop_ord]     = cmd_i.pop_more ? cmd_i.pop_next : '0;
      nonempty_d[cmd_i.pop_ord] = cmd_i.pop_more;
    end
    if (cmd_i.push) begin
      head_d[cmd_i.push_ord]     = cmd_i.push_frame;
      nonempty_d[cmd_i.push_ord] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '{default: '0};
      nonempty_q <= TopOnly;
    end else begin
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/buddy_page_allocator.sv =====
// buddy_page_allocator top level; depends on bpa_pkg, bpa_ram, bpa_free_lists
// a request runs search, then s splits (0..10) of read, pop and link, then a final read and pop;
// a failed request goes from search to done; each split is a read-modify-write of the link ram
// one request at a time: the next is taken only when the sequencer is back in idle
// a finished result waits in the output register while the next request is accepted
// reset: all frames one free block of top order headed by frame zero, memory_base zero
`default_nettype none

module buddy_page_allocator
  import bpa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request channel
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [OrdW-1:0]   request_order_i,
  // result channel
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic              granted_o,
  output      logic [FrameW-1:0] frame_index_o,
  output      logic [AddrW-1:0]  block_address_o,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output      logic [DataW-1:0]  prdata,
  output      logic              pready
);

  // sequencer codes
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SSearch = 3'd1;
  localparam logic [2:0] SRead   = 3'd2;
  localparam logic [2:0] SPop    = 3'd3;
  localparam logic [2:0] SLink   = 3'd4;
  localparam logic [2:0] SDone   = 3'd5;

  logic [2:0]       state_q, state_d;
  ord_t             req_q, req_d;
  ord_t             ord_q, ord_d;
  frame_t           head_q, head_d;
  logic             granted_q, granted_d;
  frame_t           frame_q, frame_d;
  logic [DataW-1:0] memory_base_q;
  logic             fresh_q;
  logic             rd_zero_q;

  logic             out_valid_q;
  logic             out_granted_q;
  frame_t           out_frame_q;
  logic [AddrW-1:0] out_addr_q;

  list_cmd_t  list_cmd;
  list_stat_t list_stat;

  logic             ram_we, ram_re;
  frame_t           ram_waddr, ram_raddr;
  logic [LinkW-1:0] ram_wdata, ram_rdata;

  logic             link_more;
  frame_t           link_next;
  ord_t             lower_ord;
  frame_t           upper_frame;
  logic             out_load;
  logic             cfg_write;

  // ---------------------------------------------------------------------------
  // configuration: memory_base, written in the apb access phase
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == RegMemoryBase) ? memory_base_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_base_q <= '0;
    end else if (cfg_write && (paddr == RegMemoryBase)) begin
      memory_base_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // free list heads live in flops, the successor links in the frame ram
  // ---------------------------------------------------------------------------
  bpa_free_lists u_lists (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_ord_i (req_q),
    .cur_ord_i (ord_q),
    .cmd_i     (list_cmd),
    .stat_o    (list_stat)
  );

  bpa_ram #(
    .Width (LinkW),
    .Depth (NumFrames)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // frame zero is the only entry read before it is ever written: the initial
  // top block has no successor, so its link reads as empty until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q   <= 1'b1;
      rd_zero_q <= 1'b0;
    end else begin
      if (ram_we && (ram_waddr == '0)) begin
        fresh_q <= 1'b0;
      end
      if (ram_re) begin
        rd_zero_q <= fresh_q && (ram_raddr == '0);
      end
    end
  end

  assign link_more = rd_zero_q ? 1'b0 : ram_rdata[LinkW-1];
  assign link_next = rd_zero_q ? '0 : ram_rdata[FrameW-1:0];

  // buddy of the block being split: upper half at head + 2^(order-1)
  assign lower_ord   = ord_q - OrdW'(1);
  assign upper_frame = head_q + (FrameW'(1) << lower_ord);

  // the output register frees as soon as its result is taken
  assign out_load = (state_q == SDone) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------------------
  // sequencer: search, then per split read/pop/link, then final pop
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    ord_d     = ord_q;
    head_d    = head_q;
    granted_d = granted_q;
    frame_d   = frame_q;
    list_cmd  = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          req_d   = request_order_i;
          state_d = SSearch;
        end
      end
      SSearch: begin
        // order too large or no list large enough: fail with zeroed fields
        if ((req_q > OrdW'(MaxOrder)) || !list_stat.found) begin
          granted_d = 1'b0;
          frame_d   = '0;
          state_d   = SDone;
        end else begin
          ord_d   = list_stat.found_ord;
          state_d = SRead;
        end
      end
      SRead: begin
        ram_re    = 1'b1;
        ram_raddr = list_stat.cur_head;
        head_d    = list_stat.cur_head;
        state_d   = SPop;
      end
      SPop: begin
        list_cmd.pop      = 1'b1;
        list_cmd.pop_ord  = ord_q;
        list_cmd.pop_more = link_more;
        list_cmd.pop_next = link_next;
        ram_we            = 1'b1;
        ram_wdata         = '0;
        if (ord_q > req_q) begin
          // upper half ends the lower list, lower half becomes its head
          ram_waddr           = upper_frame;
          list_cmd.push       = 1'b1;
          list_cmd.push_ord   = lower_ord;
          list_cmd.push_frame = head_q;
          state_d             = SLink;
        end else begin
          // granted block leaves the lists with its link cleared
          ram_waddr = head_q;
          granted_d = 1'b1;
          frame_d   = head_q;
          state_d   = SDone;
        end
      end
      SLink: begin
        ram_we    = 1'b1;
        ram_waddr = head_q;
        ram_wdata = {1'b1, upper_frame};
        ord_d     = lower_ord;
        state_d   = SRead;
      end
      SDone: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    ord_q     <= ord_d;
    head_q    <= head_d;
    granted_q <= granted_d;
    frame_q   <= frame_d;
  end

  assign in_stall_o = (state_q != SIdle);

  // ---------------------------------------------------------------------------
  // output register, byte address formed on load
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_granted_q <= granted_q;
      out_frame_q   <= frame_q;
      out_addr_q    <= granted_q
                       ? ({1'b0, memory_base_q} + (AddrW'(frame_q) << PageShift))
                       : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = out_granted_q;
  assign frame_index_o   = out_frame_q;
  assign block_address_o = out_addr_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPop) |-> list_stat.cur_nonempty)
    else $error("pop from an empty free list");

  a_pop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPop) |-> (ord_q >= req_q) && (ord_q <= OrdW'(MaxOrder)))
    else $error("pop order outside requested range");

  a_grant_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SDone) && granted_q)
      |-> ((frame_q & ((FrameW'(1) << req_q) - FrameW'(1))) == '0))
    else $error("granted block not aligned to its order");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SDone) && !granted_q) |-> (frame_q == '0))
    else $error("failed request carries a frame");

  a_ram_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("link ram read and written in one cycle");

endmodule

`default_nettype wire
